// ===== hdl/wms_pkg.sv =====
// Shared constants, types and helpers of the 2D sliding-window minimum block.
`timescale 1ns / 1ps
package wms_pkg;

   localparam int MAX_ROWS_DEF   = 4096;
   localparam int MAX_COLS_DEF   = 4096;
   localparam int MAX_WIN_DEF    = 64;
   localparam int PIXEL_BITS_DEF = 30;

   localparam int SUM_W      = 63;
   localparam int DIM_W      = 13;
   localparam int WIN_W      = 7;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_ROWS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_COLS = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDHEAD,
      ST_CHKHEAD,
      ST_RDTAIL,
      ST_CHKTAIL,
      ST_PUSH,
      ST_PTR,
      ST_PTRD,
      ST_EMIT,
      ST_ADV
   } state_type;

   typedef struct packed {
      logic accept;
      logic rd_tail;
      logic expire;
      logic take_front;
      logic pop;
      logic push;
      logic ptr_rd;
      logic start_col;
      logic emit;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic cnt_one;
      logic expired;
      logic tail_ge;
      logic sel_col;
      logic col_go;
      logic out_go;
      logic out_busy;
   } sts_type;

   // limit a register value to 1..hi
   function automatic logic [31:0] clamp_u(logic [31:0] v, logic [31:0] hi);
      logic [31:0] r;
      r = v;
      if (v < 32'd1) r = 32'd1;
      else if (v > hi) r = hi;
      return r;
   endfunction

endpackage

// ===== hdl/wms_if.sv =====
// Pixel request and window result channel interfaces.
`timescale 1ns / 1ps
interface wms_req_if #(parameter int PIXEL_BITS = wms_pkg::PIXEL_BITS_DEF);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface wms_rsp_if #(parameter int PIXEL_BITS = wms_pkg::PIXEL_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic [PIXEL_BITS-1:0]        window_min;
   logic [wms_pkg::SUM_W-1:0]    running_sum;
   logic                         last;
   modport source (output valid, output window_min, output running_sum, output last,
                   input ready);
   modport sink (input valid, input window_min, input running_sum, input last,
                 output ready);
endinterface

// ===== hdl/wms_ctrl.sv =====
// Sequencer for the row and column deque updates of one pixel.
`timescale 1ns / 1ps
module wms_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wms_pkg::sts_type  sts,
   output wms_pkg::cmd_type  cmd
);
   import wms_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_RDHEAD;
         ST_RDHEAD:  state_in = ST_CHKHEAD;
         ST_CHKHEAD: begin
            if (sts.cnt_zero) state_in = ST_PUSH;
            else if (sts.expired) state_in = ST_RDHEAD;
            else state_in = ST_RDTAIL;
         end
         ST_RDTAIL:  state_in = ST_CHKTAIL;
         ST_CHKTAIL: begin
            if (sts.tail_ge && !sts.cnt_one) state_in = ST_RDTAIL;
            else state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!sts.sel_col) state_in = sts.col_go ? ST_PTR : ST_ADV;
            else state_in = sts.out_go ? ST_EMIT : ST_ADV;
         end
         ST_PTR:     state_in = ST_PTRD;
         ST_PTRD:    state_in = ST_RDHEAD;
         ST_EMIT:    if (!sts.out_busy) state_in = ST_IDLE;
         ST_ADV:     state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_CHKHEAD: begin
            cmd.expire     = !sts.cnt_zero && sts.expired;
            cmd.take_front = !sts.cnt_zero && !sts.expired;
         end
         ST_RDTAIL:  cmd.rd_tail = 1'b1;
         ST_CHKTAIL: cmd.pop = sts.tail_ge;
         ST_PUSH:    cmd.push = 1'b1;
         ST_PTR:     cmd.ptr_rd = 1'b1;
         ST_PTRD:    cmd.start_col = 1'b1;
         ST_EMIT: begin
            cmd.emit    = !sts.out_busy;
            cmd.advance = !sts.out_busy;
         end
         ST_ADV:     cmd.advance = 1'b1;
         default:    cmd = '0;
      endcase
   end

endmodule

// ===== hdl/wms_dp.sv =====
// Deque memories, position counters, running sum and result register.
`timescale 1ns / 1ps
module wms_dp #(
   parameter int MAX_ROWS   = wms_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS   = wms_pkg::MAX_COLS_DEF,
   parameter int MAX_WIN    = wms_pkg::MAX_WIN_DEF,
   parameter int PIXEL_BITS = wms_pkg::PIXEL_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [wms_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wms_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [PIXEL_BITS-1:0]           pixel,
   input  wms_pkg::cmd_type                cmd,
   output wms_pkg::sts_type                sts,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [PIXEL_BITS-1:0]           rsp_window_min,
   output logic [wms_pkg::SUM_W-1:0]       rsp_running_sum,
   output logic                            rsp_last
);
   import wms_pkg::*;

   localparam int RPW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CPW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int POSW = (RPW > CPW) ? RPW : CPW;
   localparam int NRW  = $clog2(MAX_ROWS + 1);
   localparam int NCW  = $clog2(MAX_COLS + 1);
   localparam int NWW  = $clog2(MAX_WIN + 1);
   localparam int IW   = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;
   localparam int CMD  = MAX_COLS * MAX_WIN;
   localparam int KBW  = (CMD > 1) ? $clog2(CMD) : 1;
   localparam int REW  = PIXEL_BITS + CPW;
   localparam int CEW  = PIXEL_BITS + RPW;
   localparam int PEW  = IW + NWW;
   localparam logic [SUM_W:0] SUM_MAX = {1'b0, {SUM_W{1'b1}}};

   function automatic logic [IW-1:0] wrap_idx(logic [31:0] a);
      logic [31:0] r;
      r = a;
      if (a >= 32'(MAX_WIN)) r = a - 32'(MAX_WIN);
      return IW'(r);
   endfunction

   // configuration and derived sizes
   logic [DIM_W-1:0] rows_ff, cols_ff;
   logic [WIN_W-1:0] wrows_ff, wcols_ff;
   logic [NRW-1:0]   nr;
   logic [NCW-1:0]   nc;
   logic [NWW-1:0]   wr, wc;

   assign nr = NRW'(clamp_u(32'(rows_ff), 32'(MAX_ROWS)));
   assign nc = NCW'(clamp_u(32'(cols_ff), 32'(MAX_COLS)));
   assign wr = NWW'(clamp_u(32'(wrows_ff), 32'(MAX_WIN)));
   assign wc = NWW'(clamp_u(32'(wcols_ff), 32'(MAX_WIN)));

   // positions and accumulation
   logic [RPW-1:0]   r_ff;
   logic [CPW-1:0]   c_ff;
   logic [SUM_W-1:0] sum_ff;

   // working deque
   logic                  sel_ff;
   logic [IW-1:0]         head_ff;
   logic [NWW-1:0]        cnt_ff;
   logic [POSW-1:0]       now_ff;
   logic [NWW-1:0]        win_ff;
   logic [PIXEL_BITS-1:0] val_ff, front_ff, hmin_ff, min_ff;
   logic [KBW-1:0]        kbase_ff;
   logic [IW-1:0]         row_head_ff;
   logic [NWW-1:0]        row_cnt_ff;

   // memories
   logic [REW-1:0] row_mem [MAX_WIN];
   logic [CEW-1:0] col_mem [CMD];
   logic [PEW-1:0] ptr_mem [MAX_COLS];
   logic [REW-1:0] rrd_ff;
   logic [CEW-1:0] crd_ff;
   logic [PEW-1:0] prd_ff;

   logic [IW-1:0]         rd_idx, wr_idx;
   logic [CPW-1:0]        k_now;
   logic [PIXEL_BITS-1:0] rd_val, push_res;
   logic [31:0]           rd_pos;
   logic                  last_now;
   logic [SUM_W:0]        sum_add;
   logic [SUM_W-1:0]      sum_new;

   assign rd_idx = cmd.rd_tail ? wrap_idx(32'(head_ff) + 32'(cnt_ff) - 32'd1) : head_ff;
   assign wr_idx = wrap_idx(32'(head_ff) + 32'(cnt_ff));
   assign k_now  = CPW'(32'(c_ff) + 32'd1 - 32'(wc));
   assign rd_val = sel_ff ? crd_ff[CEW-1:RPW] : rrd_ff[REW-1:CPW];
   assign rd_pos = sel_ff ? 32'(crd_ff[RPW-1:0]) : 32'(rrd_ff[CPW-1:0]);
   assign push_res = (cnt_ff == '0) ? val_ff : front_ff;
   assign last_now = (32'(r_ff) == 32'(nr) - 32'd1) && (32'(c_ff) == 32'(nc) - 32'd1);
   assign sum_add  = {1'b0, sum_ff} + (SUM_W + 1)'(min_ff);
   assign sum_new  = sum_add[SUM_W] ? SUM_MAX[SUM_W-1:0] : sum_add[SUM_W-1:0];

   assign sts.cnt_zero = (cnt_ff == '0);
   assign sts.cnt_one  = (cnt_ff == NWW'(1));
   assign sts.expired  = (32'(now_ff) - rd_pos) >= 32'(win_ff);
   assign sts.tail_ge  = (rd_val >= val_ff);
   assign sts.sel_col  = sel_ff;
   assign sts.col_go   = (32'(c_ff) + 32'd1) >= 32'(wc);
   assign sts.out_go   = (32'(r_ff) + 32'd1) >= 32'(wr);
   assign sts.out_busy = rsp_valid && !rsp_ready;

   always_ff @(posedge clock) begin
      rrd_ff <= row_mem[rd_idx];
      crd_ff <= col_mem[kbase_ff + KBW'(rd_idx)];
      prd_ff <= ptr_mem[k_now];
      if (cmd.push && !sel_ff) row_mem[wr_idx] <= {val_ff, CPW'(now_ff)};
      if (cmd.push && sel_ff) begin
         col_mem[kbase_ff + KBW'(wr_idx)] <= {val_ff, RPW'(now_ff)};
         ptr_mem[k_now] <= {head_ff, cnt_ff + NWW'(1)};
      end
   end

   // working deque registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sel_ff  <= 1'b0;
         val_ff  <= pixel;
         head_ff <= (c_ff == '0) ? '0 : row_head_ff;
         cnt_ff  <= (c_ff == '0) ? '0 : row_cnt_ff;
         now_ff  <= POSW'(c_ff);
         win_ff  <= wc;
      end
      if (cmd.ptr_rd) begin
         sel_ff   <= 1'b1;
         val_ff   <= hmin_ff;
         now_ff   <= POSW'(r_ff);
         win_ff   <= wr;
         kbase_ff <= KBW'(32'(k_now) * 32'(MAX_WIN));
      end
      if (cmd.start_col) begin
         head_ff <= (r_ff == '0) ? '0 : prd_ff[PEW-1:NWW];
         cnt_ff  <= (r_ff == '0) ? '0 : prd_ff[NWW-1:0];
      end
      if (cmd.expire) begin
         head_ff <= wrap_idx(32'(head_ff) + 32'd1);
         cnt_ff  <= cnt_ff - NWW'(1);
      end
      if (cmd.take_front) front_ff <= rd_val;
      if (cmd.pop) cnt_ff <= cnt_ff - NWW'(1);
      if (cmd.push) begin
         if (sel_ff) min_ff <= push_res;
         else hmin_ff <= push_res;
      end
   end

   // control state: configuration, positions, row deque pointers, sum, result
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff     <= DIM_W'(1);
         cols_ff     <= DIM_W'(1);
         wrows_ff    <= WIN_W'(1);
         wcols_ff    <= WIN_W'(1);
         r_ff        <= '0;
         c_ff        <= '0;
         sum_ff      <= '0;
         row_head_ff <= '0;
         row_cnt_ff  <= '0;
         rsp_valid   <= 1'b0;
      end else begin
         if (cmd.push && !sel_ff) begin
            row_head_ff <= head_ff;
            row_cnt_ff  <= cnt_ff + NWW'(1);
         end
         if (cmd.emit) begin
            rsp_valid       <= 1'b1;
            rsp_window_min  <= min_ff;
            rsp_running_sum <= sum_new;
            rsp_last        <= last_now;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_ROWS:     rows_ff  <= csr_wdata[DIM_W-1:0];
               CSR_COLS:     cols_ff  <= csr_wdata[DIM_W-1:0];
               CSR_WIN_ROWS: wrows_ff <= csr_wdata[WIN_W-1:0];
               CSR_WIN_COLS: wcols_ff <= csr_wdata[WIN_W-1:0];
               default:      rows_ff  <= rows_ff;
            endcase
            // restart the image
            r_ff   <= '0;
            c_ff   <= '0;
            sum_ff <= '0;
         end else if (cmd.advance) begin
            if (last_now) begin
               r_ff   <= '0;
               c_ff   <= '0;
               sum_ff <= '0;
            end else begin
               if (cmd.emit) sum_ff <= sum_new;
               if ((32'(c_ff) + 32'd1) >= 32'(nc)) begin
                  c_ff <= '0;
                  r_ff <= r_ff + RPW'(1);
               end else begin
                  c_ff <= c_ff + CPW'(1);
               end
            end
         end
      end
   end

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> cnt_ff != '0)
      else $error("deque pop with empty deque");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("result beat not presented after emit");
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.push && !sel_ff && !csr_we |=> 32'(row_cnt_ff) <= 32'(wc))
      else $error("row deque holds more than a window");
`endif

endmodule

// ===== hdl/window_min_sum_2d_core.sv =====
// Sequence: a pixel taken in ST_IDLE updates the row deque (ST_RDHEAD/ST_CHKHEAD per head
// entry, ST_RDTAIL/ST_CHKTAIL per tail entry, ST_PUSH), then, if it feeds a column deque,
// ST_PTR/ST_PTRD load that deque for the same steps; ST_EMIT registers a full window's result.
// One pixel at a time; on average about one entry per deque per pixel is expired or dropped.
// Reset: synchronous, active high; sizes return to 1, positions and sum clear; deque
// memories need no clearing pass since the first row and first column start empty.
`timescale 1ns / 1ps
module window_min_sum_2d_core #(
   parameter int MAX_ROWS   = wms_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS   = wms_pkg::MAX_COLS_DEF,
   parameter int MAX_WIN    = wms_pkg::MAX_WIN_DEF,
   parameter int PIXEL_BITS = wms_pkg::PIXEL_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   wms_req_if.sink                        req_ch,
   wms_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [wms_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wms_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wms_pkg::*;

   cmd_type cmd;
   sts_type sts;

   wms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wms_dp #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .MAX_WIN    (MAX_WIN),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pixel           (req_ch.pixel),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_window_min  (rsp_ch.window_min),
      .rsp_running_sum (rsp_ch.running_sum),
      .rsp_last        (rsp_ch.last)
   );

endmodule
